FILE: design/grc_pkg.sv
// Shared constants, codes, types and the CORDIC arctangent table of the grid ray caster.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package grc_pkg;

	localparam int MAP_DIM     = 64;
	localparam int DIM_W       = $clog2(MAP_DIM);
	localparam int CELL_W      = 2 * DIM_W;
	localparam int CELLS       = MAP_DIM * MAP_DIM;
	localparam int WALK_STEPS  = MAP_DIM + 2;
	localparam int STEP_W      = $clog2(WALK_STEPS + 1);
	localparam int ANGLE_W     = 12;
	localparam int EYE_W       = 19;
	localparam int OUT_W       = 17;
	localparam int FRAC_BITS   = 8;
	localparam int TAN_FRAC    = 14;
	localparam int SLOPE_W     = 24;
	localparam int LIMIT_W     = 23;
	localparam int CORDIC_STEPS = 28;
	localparam int ITER_W      = 5;
	localparam int POS_W       = 40;   // walk coordinates, Q.8 with plenty of headroom
	localparam int MAG_W       = 30;   // |x|, |y| of the CORDIC vector
	localparam int NUM_W       = MAG_W + TAN_FRAC;
	localparam int QUO_W       = 24;
	localparam int CFG_W       = 7;

	localparam logic [LIMIT_W-1:0]        TAN_LIMIT  = 23'd8388607;
	localparam logic signed [31:0]        TWO_PI_Q28 = 32'sd1686629713;
	localparam logic signed [31:0]        CORDIC_X0  = 32'sd268435456;
	localparam logic signed [31:0]        DIST_CLAMP = 32'sd2147483647;

	typedef enum logic [1:0] {
		CFG_TILE_SHIFT = 2'd0,
		CFG_MAP_WIDTH  = 2'd1,
		CFG_MAP_HEIGHT = 2'd2
	} cfg_idx_t;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_CAST  = 1'b1;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [MAG_W-1:0] den;
	} div_cmd_t;

	typedef struct packed {
		logic               done;
		logic [LIMIT_W-1:0] mag;
	} div_rsp_t;

	typedef struct packed {
		logic              we;
		logic [CELL_W-1:0] addr;
		logic              data;
	} wm_wr_t;

	// atan(2^-i) in Q28
	function automatic logic signed [31:0] atan_q28(input logic [ITER_W-1:0] i);
		logic signed [31:0] v;
		case (i)
			5'd0:  v = 32'sd210828714;
			5'd1:  v = 32'sd124459457;
			5'd2:  v = 32'sd65760959;
			5'd3:  v = 32'sd33381290;
			5'd4:  v = 32'sd16755422;
			5'd5:  v = 32'sd8385879;
			5'd6:  v = 32'sd4193963;
			5'd7:  v = 32'sd2097109;
			5'd8:  v = 32'sd1048571;
			5'd9:  v = 32'sd524287;
			5'd10: v = 32'sd262144;
			5'd11: v = 32'sd131072;
			5'd12: v = 32'sd65536;
			5'd13: v = 32'sd32768;
			5'd14: v = 32'sd16384;
			5'd15: v = 32'sd8192;
			5'd16: v = 32'sd4096;
			5'd17: v = 32'sd2048;
			5'd18: v = 32'sd1024;
			5'd19: v = 32'sd512;
			5'd20: v = 32'sd256;
			5'd21: v = 32'sd128;
			5'd22: v = 32'sd64;
			5'd23: v = 32'sd32;
			5'd24: v = 32'sd16;
			5'd25: v = 32'sd8;
			5'd26: v = 32'sd4;
			5'd27: v = 32'sd2;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

FILE: design/grc_req_if.sv
// Request channel of the grid ray caster: valid/ready plus one request beat.
// Depends on grc_pkg for field widths.
`timescale 1ns / 1ps

interface grc_req_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [grc_pkg::CELL_W-1:0]    cell_index;
	logic                          cell_is_wall;
	logic [grc_pkg::EYE_W-1:0]     eye_x;
	logic [grc_pkg::EYE_W-1:0]     eye_y;
	logic [grc_pkg::ANGLE_W-1:0]   ray_angle;

	modport source (output valid, req_type, cell_index, cell_is_wall, eye_x, eye_y, ray_angle,
		input ready);
	modport sink (input valid, req_type, cell_index, cell_is_wall, eye_x, eye_y, ray_angle,
		output ready);
endinterface

FILE: design/grc_res_if.sv
// Result channel of the grid ray caster: valid/ready plus one hit beat.
// Depends on grc_pkg for field widths.
`timescale 1ns / 1ps

interface grc_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [grc_pkg::OUT_W-1:0]  hit_x;
	logic signed [grc_pkg::OUT_W-1:0]  hit_y;
	logic                              hit_on_vertical;
	logic                              hit_is_wall;

	modport source (output valid, hit_x, hit_y, hit_on_vertical, hit_is_wall, input ready);
	modport sink (input valid, hit_x, hit_y, hit_on_vertical, hit_is_wall, output ready);
endinterface

FILE: design/grc_divider.sv
// Restoring divider, one quotient bit per cycle, saturating at the tan/cot limit.
// Depends on grc_pkg for the command and response types.
`timescale 1ns / 1ps

module grc_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  grc_pkg::div_cmd_t cmd,
	output grc_pkg::div_rsp_t rsp
);

	logic                            run_q;
	logic                            done_q;
	logic [$clog2(grc_pkg::QUO_W+1)-1:0] cnt_q;
	logic                            ovf_q;
	logic [grc_pkg::MAG_W-1:0]       rem_q;
	logic [grc_pkg::MAG_W-1:0]       den_q;
	logic [grc_pkg::QUO_W-1:0]       num_q;
	logic [grc_pkg::QUO_W-1:0]       quo_q;
	logic [grc_pkg::MAG_W:0]         trial;
	logic                            fits;

	assign trial = {rem_q, num_q[grc_pkg::QUO_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			rem_q  <= '0;
			den_q  <= '0;
			num_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start && !run_q) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				den_q <= cmd.den;
				num_q <= cmd.num[grc_pkg::QUO_W-1:0];
				rem_q <= grc_pkg::MAG_W'(cmd.num[grc_pkg::NUM_W-1:grc_pkg::QUO_W]);
				// quotient of 2^24 or more when the high part alone reaches the divisor
				ovf_q <= grc_pkg::MAG_W'(cmd.num[grc_pkg::NUM_W-1:grc_pkg::QUO_W]) >= cmd.den;
				quo_q <= '0;
			end else if (run_q) begin
				num_q <= num_q << 1;
				if (fits) begin
					rem_q <= grc_pkg::MAG_W'(trial - {1'b0, den_q});
					quo_q <= {quo_q[grc_pkg::QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[grc_pkg::MAG_W-1:0];
					quo_q <= {quo_q[grc_pkg::QUO_W-2:0], 1'b0};
				end
				if (cnt_q == ($bits(cnt_q))'(grc_pkg::QUO_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.mag  = (ovf_q || quo_q[grc_pkg::QUO_W-1]) ? grc_pkg::TAN_LIMIT
		: quo_q[grc_pkg::LIMIT_W-1:0];

endmodule

FILE: design/grc_wall_map.sv
// Wall bit store, 64 x 64 cells, one write (ignored while busy) and one registered read per cycle.
// After reset a sweep clears every cell; busy stays high for its length. Uses grc_pkg.
`timescale 1ns / 1ps

module grc_wall_map (
	input  logic                       clk,
	input  logic                       arst_n,
	input  grc_pkg::wm_wr_t            wr,
	input  logic [grc_pkg::CELL_W-1:0] rd_addr,
	output logic                       rd_data,
	output logic                       busy
);

	logic                       mem_q [grc_pkg::CELLS];
	logic [grc_pkg::CELL_W:0]   clr_q;
	logic                       rd_q;

	assign busy = !clr_q[grc_pkg::CELL_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			mem_q[clr_q[grc_pkg::CELL_W-1:0]] <= 1'b0;
		end else if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

FILE: design/grc_divider_wrap_note.sv
// Saturating signed fixed point helper: floor to whole pixels, clamped to the OUT_W signed range.
// Depends on grc_pkg; used by the grid ray caster top level.
`timescale 1ns / 1ps

module grc_pix_sat (
	input  logic signed [grc_pkg::POS_W-1:0] v,
	output logic signed [grc_pkg::OUT_W-1:0] pix
);

	logic signed [grc_pkg::POS_W-1:0] fl;

	always_comb begin
		fl = v >>> grc_pkg::FRAC_BITS;
		if (fl > grc_pkg::POS_W'(65535))
			pix = 17'sd65535;
		else if (fl < -grc_pkg::POS_W'(65536))
			pix = -17'sd65536;
		else
			pix = fl[grc_pkg::OUT_W-1:0];
	end

endmodule

FILE: design/grid_ray_caster.sv
// Grid ray caster. Request beats on req either write one wall cell (req_type 0, no result)
// or cast a ray (req_type 1, one beat on res). cfg_we/cfg_index/cfg_data set tile_shift,
// map_width and map_height; the user writes them only while the block is idle, which the
// block itself does not enforce. A cast runs under one sequencer: a 13x31 multiply for the
// CORDIC angle, 28 CORDIC iterations, two divisions for tan and cot, then for each of the
// two grid walks the setup states WSET, WM1, WM2 and WM3 and up to 66 tile steps, each a
// read of the map, and a squared-distance compare on the shared 32x32 multiplier when
// both walks ran. A pass skipped on an axis, or a division skipped when x is not positive
// or y is zero, shortens a cast; the walk steps through the map read port and the divider
// set its length. req.ready is low for the whole cast.
// Reset clears the registers to 5, 32, 32 and sweeps the wall map to open, one cell per
// cycle: req.ready stays low until the sweep ends.
// The result sits in an output register; while res is stalled the block still takes cell
// writes and a new cast, and holds that cast's result until the register frees.
`timescale 1ns / 1ps

module grid_ray_caster (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [grc_pkg::CFG_W-1:0]    cfg_data,
	grc_req_if.sink                      req,
	grc_res_if.source                    res
);

	localparam int PW = grc_pkg::POS_W;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ZMUL, ST_ZTRUNC, ST_CORDIC, ST_TDIV, ST_TWAIT, ST_CDIV, ST_CWAIT,
		ST_PASS_H, ST_PASS_V, ST_WSET, ST_WM1, ST_WM2, ST_WM3, ST_WALK, ST_CMP,
		ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_SQ4, ST_PICK, ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [2:0] tile_shift_q;
	logic [6:0] map_width_q, map_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_shift_q <= 3'd5;
			map_width_q  <= 7'd32;
			map_height_q <= 7'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				grc_pkg::CFG_TILE_SHIFT: tile_shift_q <= cfg_data[2:0];
				grc_pkg::CFG_MAP_WIDTH:  map_width_q  <= cfg_data;
				grc_pkg::CFG_MAP_HEIGHT: map_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// submodules
	grc_pkg::div_cmd_t div_cmd;
	grc_pkg::div_rsp_t div_rsp;
	grc_pkg::wm_wr_t   wm_wr;
	logic [grc_pkg::CELL_W-1:0] wm_raddr;
	logic wm_rdata, wm_busy;

	grc_divider u_div (.clk(clk), .arst_n(arst_n), .cmd(div_cmd), .rsp(div_rsp));

	grc_wall_map u_map (.clk(clk), .arst_n(arst_n), .wr(wm_wr), .rd_addr(wm_raddr),
		.rd_data(wm_rdata), .busy(wm_busy));

	// cast context
	logic [grc_pkg::EYE_W-1:0]   ex_q, ey_q;
	logic signed [14:0]          q_q;
	logic                        pos_q, plus_h_q, plus_v_q, axis_h_q, axis_v_q;
	logic [3:0]                  sh_q;
	logic [6:0]                  w_q, h_q;
	logic signed [31:0]          x_q, y_q, z_q;
	logic [grc_pkg::ITER_W-1:0]  i_q;
	logic signed [grc_pkg::SLOPE_W-1:0] tq_q, cq_q, slope_n_q;

	// walk
	logic                        vert_q, plus_q;
	logic signed [PW-1:0]        a_q, b_q, db_q;
	logic [grc_pkg::STEP_W-1:0]  cnt_q;
	logic                        chk_v_s1, chk_oob_s1;
	logic signed [PW-1:0]        chk_a_s1, chk_b_s1;
	logic signed [PW-1:0]        hx_q, hy_q, vx_q, vy_q;
	logic                        hwall_q, vwall_q, hvalid_q, vvalid_q;
	logic [63:0]                 dh_q, dv_q;

	// result
	logic signed [PW-1:0]        fin_x_q, fin_y_q;
	logic                        fin_vert_q, fin_wall_q;
	logic                        res_valid_q;
	logic signed [grc_pkg::OUT_W-1:0] res_x_q, res_y_q;
	logic                        res_vert_q, res_wall_q;
	logic signed [grc_pkg::OUT_W-1:0] pix_x, pix_y;

	grc_pix_sat u_pix_x (.v(fin_x_q), .pix(pix_x));
	grc_pix_sat u_pix_y (.v(fin_y_q), .pix(pix_y));

	// shared multiplier
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p, mul_q;
	assign mul_p = mul_a * mul_b;

	// handshake
	logic accept;
	assign req.ready = (state_q == ST_IDLE) && !wm_busy;
	assign accept    = req.valid && req.ready;

	assign wm_wr.we   = accept && (req.req_type == grc_pkg::REQ_WRITE);
	assign wm_wr.addr = req.cell_index;
	assign wm_wr.data = req.cell_is_wall;

	// request decode
	logic [13:0]        q4;
	logic signed [14:0] q_red;
	logic [2:0]         ts_c;
	logic [6:0]         w_c, h_c;

	always_comb begin
		q4 = {req.ray_angle, 2'b00};
		if (q4 > 14'd12288)
			q_red = $signed({1'b0, q4}) - 15'sd16384;
		else if (q4 > 14'd4096)
			q_red = $signed({1'b0, q4}) - 15'sd8192;
		else
			q_red = $signed({1'b0, q4});
		ts_c = (tile_shift_q < 3'd3) ? 3'd3 : ((tile_shift_q > 3'd6) ? 3'd6 : tile_shift_q);
		w_c  = (map_width_q == 7'd0) ? 7'd1 : ((map_width_q > 7'd64) ? 7'd64 : map_width_q);
		h_c  = (map_height_q == 7'd0) ? 7'd1 : ((map_height_q > 7'd64) ? 7'd64 : map_height_q);
	end

	// walk datapath
	logic signed [PW-1:0] tile, a0_w, b0_w, la, lb, row, col, step_a;
	logic                 oob;
	logic                 plus_w;

	always_comb begin
		tile   = PW'(1) << sh_q;
		a0_w   = vert_q ? PW'(ex_q) : PW'(ey_q);
		b0_w   = vert_q ? PW'(ey_q) : PW'(ex_q);
		plus_w = vert_q ? plus_v_q : plus_h_q;
		la     = (a_q >>> sh_q) - (plus_q ? PW'(0) : PW'(1));
		lb     = b_q >>> sh_q;
		row    = vert_q ? lb : la;
		col    = vert_q ? la : lb;
		oob    = row < 0 || row >= $signed(PW'(h_q)) || col < 0 || col >= $signed(PW'(w_q));
		wm_raddr = {row[grc_pkg::DIM_W-1:0], col[grc_pkg::DIM_W-1:0]};
		step_a = plus_q ? a_q + tile : a_q - tile;
	end

	logic stop;
	assign stop = chk_oob_s1 || wm_rdata;

	// CORDIC
	logic signed [31:0] xs, ys;
	logic signed [63:0] zt;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign zt = mul_q + ((mul_q < 0) ? 64'sd16383 : 64'sd0);

	function automatic logic [31:0] abs_sat(input logic signed [PW-1:0] d);
		logic signed [PW-1:0] m;
		m = (d < 0) ? -d : d;
		if (m > PW'(grc_pkg::DIST_CLAMP))
			return 32'(grc_pkg::DIST_CLAMP);
		return m[31:0];
	endfunction

	logic [31:0] mag_x, mag_y;
	assign mag_x = (x_q < 0) ? 32'(-x_q) : 32'(x_q);
	assign mag_y = (y_q < 0) ? 32'(-y_q) : 32'(y_q);

	always_comb begin
		div_cmd.start = 1'b0;
		div_cmd.num   = {mag_y[grc_pkg::MAG_W-1:0], grc_pkg::TAN_FRAC'(0)};
		div_cmd.den   = mag_x[grc_pkg::MAG_W-1:0];
		if (state_q == ST_TDIV) begin
			div_cmd.start = x_q > 0;
		end else if (state_q == ST_CDIV) begin
			div_cmd.start = y_q != 0;
			div_cmd.num   = {mag_x[grc_pkg::MAG_W-1:0], grc_pkg::TAN_FRAC'(0)};
			div_cmd.den   = mag_y[grc_pkg::MAG_W-1:0];
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_ZMUL: begin
				mul_a = 32'(q_q);
				mul_b = grc_pkg::TWO_PI_Q28;
			end
			ST_WM1: begin
				mul_a = 32'(a_q - a0_w);
				mul_b = 32'(slope_n_q);
			end
			ST_WM2: begin
				mul_a = plus_q ? 32'(tile) : -32'(tile);
				mul_b = 32'(slope_n_q);
			end
			ST_SQ0: begin
				mul_a = abs_sat(hx_q - PW'(ex_q));
				mul_b = mul_a;
			end
			ST_SQ1: begin
				mul_a = abs_sat(hy_q - PW'(ey_q));
				mul_b = mul_a;
			end
			ST_SQ2: begin
				mul_a = abs_sat(vx_q - PW'(ex_q));
				mul_b = mul_a;
			end
			ST_SQ3: begin
				mul_a = abs_sat(vy_q - PW'(ey_q));
				mul_b = mul_a;
			end
			default: ;
		endcase
	end

	logic signed [grc_pkg::SLOPE_W-1:0] lim_p, lim_s, mag_s;
	assign lim_p = grc_pkg::SLOPE_W'(grc_pkg::TAN_LIMIT);
	assign lim_s = pos_q ? lim_p : -lim_p;
	assign mag_s = grc_pkg::SLOPE_W'(div_rsp.mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			chk_v_s1    <= 1'b0;
			cnt_q       <= '0;
			vert_q      <= 1'b0;
			hvalid_q    <= 1'b0;
			vvalid_q    <= 1'b0;
			mul_q       <= '0;
		end else begin
			mul_q <= mul_p;
			// in ST_DONE the output register is reloaded below instead
			if (res_valid_q && res.ready && state_q != ST_DONE)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req.req_type == grc_pkg::REQ_CAST) begin
						ex_q     <= req.eye_x;
						ey_q     <= req.eye_y;
						q_q      <= q_red;
						pos_q    <= q_red >= 0;
						plus_h_q <= req.ray_angle >= 12'd2048;
						plus_v_q <= req.ray_angle < 12'd1024 || req.ray_angle > 12'd3072;
						// angle is a multiple of a quarter step, so the axis band is exact
						axis_h_q <= req.ray_angle[9:0] == 10'd0 && !req.ray_angle[10];
						axis_v_q <= req.ray_angle[9:0] == 10'd0 && req.ray_angle[10];
						sh_q     <= 4'(ts_c) + 4'(grc_pkg::FRAC_BITS);
						w_q      <= w_c;
						h_q      <= h_c;
						state_q  <= ST_ZMUL;
					end
				end
				ST_ZMUL: state_q <= ST_ZTRUNC;
				ST_ZTRUNC: begin
					z_q     <= 32'(zt >>> grc_pkg::TAN_FRAC);
					x_q     <= grc_pkg::CORDIC_X0;
					y_q     <= '0;
					i_q     <= '0;
					state_q <= ST_CORDIC;
				end
				ST_CORDIC: begin
					if (z_q >= 0) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - grc_pkg::atan_q28(i_q);
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + grc_pkg::atan_q28(i_q);
					end
					i_q <= i_q + 1'b1;
					if (i_q == grc_pkg::ITER_W'(grc_pkg::CORDIC_STEPS - 1))
						state_q <= ST_TDIV;
				end
				ST_TDIV: begin
					if (x_q <= 0) begin
						tq_q    <= lim_s;
						state_q <= ST_CDIV;
					end else begin
						state_q <= ST_TWAIT;
					end
				end
				ST_TWAIT: begin
					if (div_rsp.done) begin
						tq_q    <= (y_q < 0) ? -mag_s : mag_s;
						state_q <= ST_CDIV;
					end
				end
				ST_CDIV: begin
					if (y_q == 0) begin
						cq_q    <= lim_s;
						state_q <= ST_PASS_H;
					end else begin
						state_q <= ST_CWAIT;
					end
				end
				ST_CWAIT: begin
					if (div_rsp.done) begin
						cq_q    <= (x_q[31] ^ y_q[31]) ? -mag_s : mag_s;
						state_q <= ST_PASS_H;
					end
				end
				ST_PASS_H: begin
					hvalid_q <= !axis_h_q;
					vert_q   <= axis_h_q;
					state_q  <= axis_h_q ? ST_PASS_V : ST_WSET;
				end
				ST_PASS_V: begin
					vvalid_q <= !axis_v_q;
					vert_q   <= 1'b1;
					state_q  <= axis_v_q ? ST_CMP : ST_WSET;
				end
				ST_WSET: begin
					a_q       <= (a0_w & ~(tile - PW'(1))) + (plus_w ? tile : PW'(0));
					b_q       <= b0_w;
					plus_q    <= plus_w;
					slope_n_q <= vert_q ? -tq_q : -cq_q;
					state_q   <= ST_WM1;
				end
				ST_WM1: state_q <= ST_WM2;
				ST_WM2: begin
					b_q     <= b_q + PW'(mul_q >>> grc_pkg::TAN_FRAC);
					state_q <= ST_WM3;
				end
				ST_WM3: begin
					db_q     <= PW'(mul_q >>> grc_pkg::TAN_FRAC);
					cnt_q    <= '0;
					chk_v_s1 <= 1'b0;
					state_q  <= ST_WALK;
				end
				ST_WALK: begin
					// issue one cell read per cycle; its check lands in the next cycle
					chk_v_s1 <= 1'b0;
					if (cnt_q != grc_pkg::STEP_W'(grc_pkg::WALK_STEPS)) begin
						chk_v_s1   <= 1'b1;
						chk_oob_s1 <= oob;
						chk_a_s1   <= a_q;
						chk_b_s1   <= b_q;
						a_q        <= step_a;
						b_q        <= b_q + db_q;
						cnt_q      <= cnt_q + 1'b1;
					end
					if (chk_v_s1 && (stop ||
						cnt_q == grc_pkg::STEP_W'(grc_pkg::WALK_STEPS))) begin
						chk_v_s1 <= 1'b0;
						if (vert_q) begin
							vx_q    <= stop ? chk_a_s1 : a_q;
							vy_q    <= stop ? chk_b_s1 : b_q;
							vwall_q <= stop && !chk_oob_s1;
							state_q <= ST_CMP;
						end else begin
							hx_q    <= stop ? chk_b_s1 : b_q;
							hy_q    <= stop ? chk_a_s1 : a_q;
							hwall_q <= stop && !chk_oob_s1;
							state_q <= ST_PASS_V;
						end
					end
				end
				ST_CMP: state_q <= (hvalid_q && vvalid_q) ? ST_SQ0 : ST_PICK;
				ST_SQ0: state_q <= ST_SQ1;
				ST_SQ1: begin
					dh_q    <= 64'(mul_q);
					state_q <= ST_SQ2;
				end
				ST_SQ2: begin
					dh_q    <= dh_q + 64'(mul_q);
					state_q <= ST_SQ3;
				end
				ST_SQ3: begin
					dv_q    <= 64'(mul_q);
					state_q <= ST_SQ4;
				end
				ST_SQ4: begin
					dv_q    <= dv_q + 64'(mul_q);
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					if (!hvalid_q && !vvalid_q) begin
						fin_x_q    <= PW'(ex_q);
						fin_y_q    <= PW'(ey_q);
						fin_wall_q <= 1'b0;
						fin_vert_q <= 1'b0;
					end else if (vvalid_q && (!hvalid_q || !(dh_q < dv_q))) begin
						// ties go to the vertical pass
						fin_x_q    <= vx_q;
						fin_y_q    <= vy_q;
						fin_wall_q <= vwall_q;
						fin_vert_q <= 1'b1;
					end else begin
						fin_x_q    <= hx_q;
						fin_y_q    <= hy_q;
						fin_wall_q <= hwall_q;
						fin_vert_q <= 1'b0;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						res_x_q     <= pix_x;
						res_y_q     <= pix_y;
						res_vert_q  <= fin_vert_q;
						res_wall_q  <= fin_wall_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid           = res_valid_q;
	assign res.hit_x           = res_x_q;
	assign res.hit_y           = res_y_q;
	assign res.hit_on_vertical = res_vert_q;
	assign res.hit_is_wall     = res_wall_q;

endmodule
